/* rtl/mtp_pkg.sv */
// Shared constants, types and state codes for the median-time-past window.
`timescale 1ns / 1ps
package mtp_pkg;

  localparam int WINDOW    = 11;
  localparam int DATA_W    = 32;
  localparam int OUT_CNT_W = 4;
  localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);

  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic en;
    idx_t idx_w;
    idx_t idx_v;
  } rank_ctl_t;

endpackage

/* rtl/median_time_past_window.sv */
// Top level: sliding-window median-time-past of the last 11 block timestamps.
`timescale 1ns / 1ps
// Each accepted timestamp is pushed into an 11-entry window (oldest replaced once
// full) and one result follows: the element at sorted index count/2 plus the count.
// The median is found by ranking candidates one at a time against every held entry
// through a single read port and one comparator, each candidate in slot order taking
// a full pass over the held entries; the search stops at the first candidate whose
// rank is count/2. in_stall is high for the whole search; a finished result waits in
// the output register while the next timestamp is accepted.
module median_time_past_window (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_median_time,
  output logic [3:0]  out_window_count
);

  mtp_pkg::state_t   state_r, state_nxt;
  mtp_pkg::cnt_t     count_r, count_nxt;
  mtp_pkg::idx_t     oldest_r, oldest_nxt;
  mtp_pkg::cnt_t     i_r, i_nxt;
  mtp_pkg::cnt_t     j_r, j_nxt;
  logic              pend_r, pend_nxt;
  mtp_pkg::idx_t     pend_idx_r, pend_idx_nxt;
  logic              first_r, first_nxt;
  mtp_pkg::data_t    v_r, v_nxt;
  logic              out_valid_r, out_valid_nxt;
  mtp_pkg::data_t    out_med_r, out_med_nxt;
  mtp_pkg::cnt_t     out_cnt_r, out_cnt_nxt;

  logic              accept;
  logic              we;
  mtp_pkg::idx_t     waddr;
  mtp_pkg::idx_t     raddr;
  mtp_pkg::data_t    rdata;
  mtp_pkg::rank_ctl_t rank_ctl;
  mtp_pkg::cnt_t     rank_sum;
  mtp_pkg::cnt_t     target;

  assign in_stall         = (state_r != mtp_pkg::ST_IDLE);
  assign accept           = in_valid && !in_stall;
  assign out_valid        = out_valid_r;
  assign out_median_time  = out_med_r;
  assign out_window_count = mtp_pkg::out_cnt_t'(out_cnt_r);
  assign target           = count_r >> 1;

  mtp_window_ram u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (in_timestamp),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  mtp_rank_unit u_rank (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rank_ctl),
    .cand     (v_r),
    .entry    (rdata),
    .rank_sum (rank_sum)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    oldest_nxt    = oldest_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    first_nxt     = 1'b0;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_med_nxt   = out_med_r;
    out_cnt_nxt   = out_cnt_r;
    we            = 1'b0;
    waddr         = oldest_r;
    raddr         = i_r[mtp_pkg::IDX_W-1:0];
    rank_ctl      = '{clear: 1'b0, en: 1'b0, idx_w: pend_idx_r,
                      idx_v: i_r[mtp_pkg::IDX_W-1:0]};

    case (state_r)
      mtp_pkg::ST_IDLE: begin
        if (accept) begin
          we = 1'b1;
          if (count_r < mtp_pkg::cnt_t'(mtp_pkg::WINDOW)) begin
            waddr     = count_r[mtp_pkg::IDX_W-1:0];
            count_nxt = count_r + 1'b1;
          end else begin
            waddr      = oldest_r;
            oldest_nxt = (oldest_r == mtp_pkg::idx_t'(mtp_pkg::WINDOW - 1)) ?
                         '0 : oldest_r + 1'b1;
          end
          i_nxt     = '0;
          state_nxt = mtp_pkg::ST_FETCH;
        end
      end
      mtp_pkg::ST_FETCH: begin
        raddr          = i_r[mtp_pkg::IDX_W-1:0];
        rank_ctl.clear = 1'b1;
        j_nxt          = '0;
        first_nxt      = 1'b1;
        state_nxt      = mtp_pkg::ST_SCAN;
      end
      mtp_pkg::ST_SCAN: begin
        if (first_r) begin
          v_nxt = rdata;
        end
        raddr = j_r[mtp_pkg::IDX_W-1:0];
        if (j_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = j_r[mtp_pkg::IDX_W-1:0];
          j_nxt        = j_r + 1'b1;
        end
        if (pend_r) begin
          rank_ctl.en = 1'b1;
          if (mtp_pkg::cnt_t'(pend_idx_r) == count_r - 1'b1) begin
            pend_nxt = 1'b0;
            if (rank_sum == target) begin
              state_nxt = mtp_pkg::ST_DONE;
            end else begin
              i_nxt     = i_r + 1'b1;
              state_nxt = mtp_pkg::ST_FETCH;
            end
          end
        end
      end
      mtp_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_med_nxt   = v_r;
          out_cnt_nxt   = count_r;
          state_nxt     = mtp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mtp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtp_pkg::ST_IDLE;
      count_r     <= '0;
      oldest_r    <= '0;
      i_r         <= '0;
      j_r         <= '0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    v_r        <= v_nxt;
    out_med_r  <= out_med_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mtp_pkg::cnt_t'(mtp_pkg::WINDOW))
    else $error("window count above window size");

  a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cnt_r != '0))
    else $error("result with empty window");

  a_cand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtp_pkg::ST_SCAN) |-> (i_r < count_r))
    else $error("median search ran past held entries");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (in_stall && (count_r != '0)))
    else $error("not busy after transaction accepted");

endmodule

/* rtl/mtp_window_ram.sv */
// Timestamp window store: one write port, one registered read port.
`timescale 1ns / 1ps
module mtp_window_ram (
  input  logic          clk,
  input  logic          we,
  input  mtp_pkg::idx_t waddr,
  input  mtp_pkg::data_t wdata,
  input  mtp_pkg::idx_t raddr,
  output mtp_pkg::data_t rdata_r
);

  mtp_pkg::data_t mem [mtp_pkg::WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/mtp_rank_unit.sv */
// Shared rank comparator with accumulator: counts entries ordered before the candidate.
`timescale 1ns / 1ps
module mtp_rank_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  mtp_pkg::rank_ctl_t ctl,
  input  mtp_pkg::data_t    cand,
  input  mtp_pkg::data_t    entry,
  output mtp_pkg::cnt_t     rank_sum
);

  mtp_pkg::cnt_t rank_r;
  mtp_pkg::cnt_t rank_nxt;
  logic          ahead;

  always_comb begin
    ahead    = (entry < cand) || ((entry == cand) && (ctl.idx_w < ctl.idx_v));
    rank_sum = rank_r + mtp_pkg::cnt_t'(ahead);
    rank_nxt = rank_r;
    if (ctl.clear) begin
      rank_nxt = '0;
    end else if (ctl.en) begin
      rank_nxt = rank_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
    end else begin
      rank_r <= rank_nxt;
    end
  end

endmodule

/* sim/tb_top.sv */
// Testbench for median_time_past_window: directed table plus random timestamp streams.
`timescale 1ns / 1ps
module tb_top;

  localparam int N_RANDOM    = 1400;
  localparam int SEG_LEN     = 100;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;
  localparam int N_DIRECTED  = 24;

  typedef struct packed {
    mtp_pkg::data_t median;
    logic [3:0]     count;
  } mtp_result_t;

  typedef struct packed {
    mtp_pkg::data_t stamp;
    logic           typed;
    mtp_pkg::data_t median;
    logic [3:0]     count;
  } stim_row_t;

  typedef enum int {
    MODE_CHAIN,
    MODE_TIES,
    MODE_WIDE,
    MODE_EDGES
  } stamp_mode_t;

  // typed rows: fill from empty with extremes and ties, then eleven equal stamps
  localparam stim_row_t DIR_ROWS [N_DIRECTED] = '{
    '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 4'd1},
    '{32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 4'd2},
    '{32'h0000_0000, 1'b1, 32'h0000_0000, 4'd3},
    '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 4'd4},
    '{32'h8000_0000, 1'b1, 32'h8000_0000, 4'd5},
    '{32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 4'd6},
    '{32'h0000_0005, 1'b0, 32'h0, 4'd0},
    '{32'h0000_0005, 1'b0, 32'h0, 4'd0},
    '{32'h0000_0005, 1'b0, 32'h0, 4'd0},
    '{32'hAAAA_AAAA, 1'b0, 32'h0, 4'd0},
    '{32'h5555_5555, 1'b0, 32'h0, 4'd0},
    '{32'h1234_5678, 1'b0, 32'h0, 4'd0},
    '{32'h1234_5678, 1'b0, 32'h0, 4'd0},
    '{32'h1234_5678, 1'b0, 32'h0, 4'd0},
    '{32'h1234_5678, 1'b0, 32'h0, 4'd0},
    '{32'h1234_5678, 1'b0, 32'h0, 4'd0},
    '{32'h1234_5678, 1'b0, 32'h0, 4'd0},
    '{32'h1234_5678, 1'b0, 32'h0, 4'd0},
    '{32'h1234_5678, 1'b0, 32'h0, 4'd0},
    '{32'h1234_5678, 1'b0, 32'h0, 4'd0},
    '{32'h1234_5678, 1'b0, 32'h0, 4'd0},
    '{32'h1234_5678, 1'b1, 32'h1234_5678, 4'd11},
    '{32'h0000_0000, 1'b0, 32'h0, 4'd0},
    '{32'hFFFF_FFFF, 1'b0, 32'h0, 4'd0}
  };

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [31:0] in_timestamp = '0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_median_time;
  logic [3:0]  out_window_count;

  mtp_pkg::data_t win_stamps [mtp_pkg::WINDOW];
  int unsigned    win_fill   = 0;
  int unsigned    win_oldest = 0;
  mtp_result_t    pending_medians [$];
  mtp_pkg::data_t chain_stamp = 32'h5E00_0000;
  mtp_pkg::data_t tie_base;

  int     n_fail     = 0;
  int     n_sent     = 0;
  int     n_checked  = 0;
  longint n_cycles   = 0;
  bit     tx_quiet   = 1'b0;
  bit     rx_quiet   = 1'b0;
  bit     hold_req   = 1'b0;
  int     hold_left  = 0;
  int     rx_gap     = 0;

  median_time_past_window i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_timestamp     (in_timestamp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_time  (out_median_time),
    .out_window_count (out_window_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(30, 90);
  endfunction

  function automatic mtp_result_t push_stamp(mtp_pkg::data_t stamp);
    mtp_result_t    res;
    int unsigned    target;
    int unsigned    rank;
    mtp_pkg::data_t v;
    if (win_fill < mtp_pkg::WINDOW) begin
      win_stamps[win_fill] = stamp;
      win_fill++;
    end else begin
      win_stamps[win_oldest] = stamp;
      win_oldest = (win_oldest + 1) % mtp_pkg::WINDOW;
    end
    target = win_fill / 2;
    res.median = '0;
    for (int i = 0; i < win_fill; i++) begin
      v = win_stamps[i];
      rank = 0;
      for (int j = 0; j < win_fill; j++) begin
        if (win_stamps[j] < v || (win_stamps[j] == v && j < i)) rank++;
      end
      if (rank == target) res.median = v;
    end
    res.count = 4'(win_fill);
    return res;
  endfunction

  function automatic mtp_pkg::data_t next_stamp(stamp_mode_t mode);
    int k;
    k = $urandom_range(0, 31);
    case (mode)
      MODE_CHAIN: begin
        chain_stamp = chain_stamp + mtp_pkg::data_t'($urandom_range(0, 1500));
        if ($urandom_range(0, 9) == 0) begin
          chain_stamp = chain_stamp - mtp_pkg::data_t'($urandom_range(0, 3000));
        end
        return chain_stamp;
      end
      MODE_TIES: return tie_base + mtp_pkg::data_t'($urandom_range(0, 2));
      MODE_WIDE: return mtp_pkg::data_t'($urandom);
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h7FFF_FFFF;
          4: return mtp_pkg::data_t'(1) << k;
          default: return ~(mtp_pkg::data_t'(1) << k);
        endcase
      end
    endcase
  endfunction

  task automatic send_stamp(mtp_pkg::data_t stamp, bit typed, mtp_result_t typed_res);
    int          gap;
    mtp_result_t res;
    gap = tx_quiet ? 0 : gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid     <= 1'b0;
      in_timestamp <= $urandom;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_timestamp <= stamp;
    do @(posedge clk); while (in_stall);
    res = push_stamp(stamp);
    pending_medians = {pending_medians, (typed ? typed_res : res)};
    n_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_gap = rx_quiet ? 0 : gap_len();
      end
    end
  end

  always @(posedge clk) begin
    mtp_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_medians.size() == 0) begin
        $error("unexpected result: median_time %h window_count %0d",
               out_median_time, out_window_count);
        n_fail++;
      end else begin
        exp_res = pending_medians.pop_front();
        n_checked++;
        if (out_median_time !== exp_res.median) begin
          $error("median_time: expected %h, actual %h", exp_res.median, out_median_time);
          n_fail++;
        end
        if (out_window_count !== exp_res.count) begin
          $error("window_count: expected %0d, actual %0d", exp_res.count, out_window_count);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               n_cycles, pending_medians.size());
      $display("[median_time_past_window] ERROR");
      $finish;
    end
  end

  initial begin
    stamp_mode_t mode;
    int          n_seg;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      send_stamp(DIR_ROWS[r].stamp, DIR_ROWS[r].typed,
                 mtp_result_t'{DIR_ROWS[r].median, DIR_ROWS[r].count});
    end
    drain_results();

    n_seg = N_RANDOM / SEG_LEN;
    for (int s = 0; s < n_seg; s++) begin
      mode     = (s == 0) ? MODE_CHAIN : stamp_mode_t'($urandom_range(0, 3));
      tie_base = mtp_pkg::data_t'($urandom);
      tx_quiet = (s == 0) || ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      if (s == 0) hold_req = 1'b1;
      if (s == n_seg / 2) drain_results();
      for (int k = 0; k < SEG_LEN; k++) begin
        send_stamp(next_stamp(mode), 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d timestamps (%0d directed), %0d results checked in %0d cycles",
             n_sent, N_DIRECTED, n_checked, n_cycles);
    $display("fill from empty, wraparound, ties, extremes, chain-like and random streams");
    if (n_fail == 0) begin
      $display("[median_time_past_window] OK");
    end else begin
      $display("[median_time_past_window] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mtp_pkg.sv
rtl/mtp_window_ram.sv
rtl/mtp_rank_unit.sv
rtl/median_time_past_window.sv
sim/tb_top.sv
